### rtl/scene_text_tokenizer_unit_assert.svh
// ----------------------------------------------------------------------------
// Assertion macros for the scene text tokenizer
// Clocked, reset-qualified property shorthands used by the RTL modules.
// ----------------------------------------------------------------------------
`ifndef SCENE_TEXT_TOKENIZER_UNIT_ASSERT_SVH
`define SCENE_TEXT_TOKENIZER_UNIT_ASSERT_SVH

// same-cycle implication
`define STC_ASSERT_NOW(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication
`define STC_ASSERT_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

### rtl/stc_pkg.sv
// ----------------------------------------------------------------------------
// stc_pkg
// Shared types, codes and character constants of the scene text tokenizer.
// ----------------------------------------------------------------------------
`default_nettype none

package stc_pkg;

    localparam int CHAR_W = 8;
    localparam int KIND_W = 2;
    localparam int ERR_W  = 2;

    localparam int ADDR_W = 2;
    localparam logic [ADDR_W-1:0] PASS_COMMENTS_ADDR = 2'd0;

    localparam int FIFO_DEPTH = 4;
    localparam int FIFO_PTR_W = 2;
    localparam int FIFO_CNT_W = 3;

    localparam logic [KIND_W-1:0] KIND_WORD    = 2'd0;
    localparam logic [KIND_W-1:0] KIND_STR     = 2'd1;
    localparam logic [KIND_W-1:0] KIND_BRACKET = 2'd2;
    localparam logic [KIND_W-1:0] KIND_COMMENT = 2'd3;

    localparam logic [ERR_W-1:0] ERR_NONE    = 2'd0;
    localparam logic [ERR_W-1:0] ERR_UNTERM  = 2'd1;
    localparam logic [ERR_W-1:0] ERR_BAD_ESC = 2'd2;

    localparam logic [CHAR_W-1:0] CH_SPACE  = 8'h20;
    localparam logic [CHAR_W-1:0] CH_TAB    = 8'h09;
    localparam logic [CHAR_W-1:0] CH_LF     = 8'h0A;
    localparam logic [CHAR_W-1:0] CH_CR     = 8'h0D;
    localparam logic [CHAR_W-1:0] CH_QUOTE  = 8'h22;
    localparam logic [CHAR_W-1:0] CH_APOS   = 8'h27;
    localparam logic [CHAR_W-1:0] CH_HASH   = 8'h23;
    localparam logic [CHAR_W-1:0] CH_BSLASH = 8'h5C;
    localparam logic [CHAR_W-1:0] CH_LBRACK = 8'h5B;
    localparam logic [CHAR_W-1:0] CH_RBRACK = 8'h5D;
    localparam logic [CHAR_W-1:0] CH_B      = 8'h62;
    localparam logic [CHAR_W-1:0] CH_F      = 8'h66;
    localparam logic [CHAR_W-1:0] CH_N      = 8'h6E;
    localparam logic [CHAR_W-1:0] CH_R      = 8'h72;
    localparam logic [CHAR_W-1:0] CH_T      = 8'h74;
    localparam logic [CHAR_W-1:0] CH_BS     = 8'h08;
    localparam logic [CHAR_W-1:0] CH_FF     = 8'h0C;

    typedef struct packed {
        logic [CHAR_W-1:0] out_char;
        logic              has_char;
        logic [KIND_W-1:0] token_kind;
        logic              token_start;
        logic              token_end;
        logic [ERR_W-1:0]  error_code;
        logic              run_last;
    } res_t;

    // results of one item: count is 0, 1 or 2
    typedef struct packed {
        logic [1:0] count;
        res_t       res0;
        res_t       res1;
    } lex_out_t;

    function automatic res_t mk_res(input logic [CHAR_W-1:0] ch, input logic has,
                                    input logic [KIND_W-1:0] kind, input logic start,
                                    input logic fin, input logic [ERR_W-1:0] err);
        res_t r;
        r.out_char    = ch;
        r.has_char    = has;
        r.token_kind  = kind;
        r.token_start = start;
        r.token_end   = fin;
        r.error_code  = err;
        r.run_last    = 1'b0;
        return r;
    endfunction

    // {valid, decoded byte}
    function automatic logic [CHAR_W:0] escape_decode(input logic [CHAR_W-1:0] c);
        logic [CHAR_W:0] v;
        unique case (c)
            CH_B:      v = {1'b1, CH_BS};
            CH_F:      v = {1'b1, CH_FF};
            CH_N:      v = {1'b1, CH_LF};
            CH_R:      v = {1'b1, CH_CR};
            CH_T:      v = {1'b1, CH_TAB};
            CH_BSLASH: v = {1'b1, CH_BSLASH};
            CH_APOS:   v = {1'b1, CH_APOS};
            CH_QUOTE:  v = {1'b1, CH_QUOTE};
            default:   v = '0;
        endcase
        return v;
    endfunction

endpackage

`default_nettype wire

### rtl/stc_if.sv
// ----------------------------------------------------------------------------
// stc_in_if / stc_out_if
// Valid/ready word channels of the tokenizer: text bytes in, token words out.
// ----------------------------------------------------------------------------
`default_nettype none

interface stc_in_if;
    logic       valid;
    logic       ready;
    logic       func;
    logic [7:0] char_in;

    modport source (output valid, output func, output char_in, input ready);
    modport sink   (input valid, input func, input char_in, output ready);
endinterface

interface stc_out_if;
    logic       valid;
    logic       ready;
    logic [7:0] out_char;
    logic       has_char;
    logic [1:0] token_kind;
    logic       token_start;
    logic       token_end;
    logic [1:0] error_code;
    logic       run_last;

    modport source (output valid, output out_char, output has_char, output token_kind,
                    output token_start, output token_end, output error_code,
                    output run_last, input ready);
    modport sink   (input valid, input out_char, input has_char, input token_kind,
                    input token_start, input token_end, input error_code,
                    input run_last, output ready);
endinterface

`default_nettype wire

### rtl/stc_lexer.sv
// ----------------------------------------------------------------------------
// stc_lexer
// Lexer mode register and the per-byte decision producing up to two words.
// ----------------------------------------------------------------------------
`default_nettype none

`include "scene_text_tokenizer_unit_assert.svh"

module stc_lexer (
    input  wire logic              clk,
    input  wire logic              rst_n,
    input  wire logic              step,
    input  wire logic              func,
    input  wire logic [7:0]        char_in,
    input  wire logic              pass_comments,
    output stc_pkg::lex_out_t      lex
);
    import stc_pkg::*;

    typedef enum logic [6:0] {
        M_IDLE       = 7'b0000001,
        M_WORD       = 7'b0000010,
        M_STR        = 7'b0000100,
        M_ESC        = 7'b0001000,
        M_COMM       = 7'b0010000,
        M_ERR_UNTERM = 7'b0100000,
        M_ERR_ESC    = 7'b1000000
    } mode_t;

    mode_t mode_reg;
    mode_t mode_next;

    logic            is_space;
    logic            bg_emit;
    res_t            bg_res;
    mode_t           bg_mode;
    logic [CHAR_W:0] esc;
    res_t            r [2];
    logic [1:0]      n;

    assign is_space = (char_in == CH_SPACE) || (char_in == CH_LF) ||
                      (char_in == CH_TAB) || (char_in == CH_CR);
    assign esc = escape_decode(char_in);

    // token start from idle
    always_comb
    begin
        bg_emit = 1'b1;
        bg_res  = mk_res(char_in, 1'b1, KIND_WORD, 1'b1, 1'b0, ERR_NONE);
        bg_mode = M_WORD;
        priority if (is_space)
        begin
            bg_emit = 1'b0;
            bg_mode = M_IDLE;
        end
        else if (char_in == CH_QUOTE)
        begin
            bg_res  = mk_res(char_in, 1'b1, KIND_STR, 1'b1, 1'b0, ERR_NONE);
            bg_mode = M_STR;
        end
        else if ((char_in == CH_LBRACK) || (char_in == CH_RBRACK))
        begin
            bg_res  = mk_res(char_in, 1'b1, KIND_BRACKET, 1'b1, 1'b1, ERR_NONE);
            bg_mode = M_IDLE;
        end
        else if (char_in == CH_HASH)
        begin
            bg_emit = pass_comments;
            bg_res  = mk_res(char_in, 1'b1, KIND_COMMENT, 1'b1, 1'b0, ERR_NONE);
            bg_mode = M_COMM;
        end
        else
        begin
            bg_emit = 1'b1;
        end
    end

    always_comb
    begin
        r[0]      = '0;
        r[1]      = '0;
        n         = 2'd0;
        mode_next = mode_reg;
        unique case (mode_reg)
            M_WORD:
            begin
                if (func || is_space || (char_in == CH_QUOTE) ||
                    (char_in == CH_LBRACK) || (char_in == CH_RBRACK))
                begin
                    r[n[0]] = mk_res('0, 1'b0, KIND_WORD, 1'b0, 1'b1, ERR_NONE);
                    n = n + 2'd1;
                    mode_next = M_IDLE;
                    if (!func)
                    begin
                        if (bg_emit)
                        begin
                            r[n[0]] = bg_res;
                            n = n + 2'd1;
                        end
                        mode_next = bg_mode;
                    end
                end
                else
                begin
                    r[n[0]] = mk_res(char_in, 1'b1, KIND_WORD, 1'b0, 1'b0, ERR_NONE);
                    n = n + 2'd1;
                end
            end
            M_STR:
            begin
                priority if (func || (char_in == CH_LF))
                begin
                    r[n[0]] = mk_res('0, 1'b0, KIND_STR, 1'b0, 1'b0, ERR_UNTERM);
                    n = n + 2'd1;
                    mode_next = M_ERR_UNTERM;
                end
                else if (char_in == CH_QUOTE)
                begin
                    r[n[0]] = mk_res(char_in, 1'b1, KIND_STR, 1'b0, 1'b1, ERR_NONE);
                    n = n + 2'd1;
                    mode_next = M_IDLE;
                end
                else if (char_in == CH_BSLASH)
                begin
                    mode_next = M_ESC;
                end
                else
                begin
                    r[n[0]] = mk_res(char_in, 1'b1, KIND_STR, 1'b0, 1'b0, ERR_NONE);
                    n = n + 2'd1;
                end
            end
            M_ESC:
            begin
                priority if (func)
                begin
                    r[n[0]] = mk_res('0, 1'b0, KIND_STR, 1'b0, 1'b0, ERR_UNTERM);
                    n = n + 2'd1;
                    mode_next = M_ERR_UNTERM;
                end
                else if (!esc[CHAR_W])
                begin
                    r[n[0]] = mk_res('0, 1'b0, KIND_STR, 1'b0, 1'b0, ERR_BAD_ESC);
                    n = n + 2'd1;
                    mode_next = M_ERR_ESC;
                end
                else
                begin
                    r[n[0]] = mk_res(esc[CHAR_W-1:0], 1'b1, KIND_STR, 1'b0, 1'b0,
                                     ERR_NONE);
                    n = n + 2'd1;
                    mode_next = M_STR;
                end
            end
            M_COMM:
            begin
                if (func || (char_in == CH_LF) || (char_in == CH_CR))
                begin
                    if (pass_comments)
                    begin
                        r[n[0]] = mk_res('0, 1'b0, KIND_COMMENT, 1'b0, 1'b1, ERR_NONE);
                        n = n + 2'd1;
                    end
                    mode_next = M_IDLE;
                end
                else if (pass_comments)
                begin
                    r[n[0]] = mk_res(char_in, 1'b1, KIND_COMMENT, 1'b0, 1'b0, ERR_NONE);
                    n = n + 2'd1;
                end
            end
            M_ERR_UNTERM:
            begin
                r[n[0]] = mk_res('0, 1'b0, KIND_STR, 1'b0, 1'b0, ERR_UNTERM);
                n = n + 2'd1;
            end
            M_ERR_ESC:
            begin
                r[n[0]] = mk_res('0, 1'b0, KIND_STR, 1'b0, 1'b0, ERR_BAD_ESC);
                n = n + 2'd1;
            end
            default:
            begin
                // idle, and any illegal code
                mode_next = M_IDLE;
                if (!func)
                begin
                    if (bg_emit)
                    begin
                        r[n[0]] = bg_res;
                        n = n + 2'd1;
                    end
                    mode_next = bg_mode;
                end
            end
        endcase

        if (n == 2'd2)
            r[1].run_last = 1'b1;
        else if (n == 2'd1)
            r[0].run_last = 1'b1;

        lex.count = n;
        lex.res0  = r[0];
        lex.res1  = r[1];
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            mode_reg <= M_IDLE;
        else if (step)
            mode_reg <= mode_next;
    end

    `STC_ASSERT_NEXT(a_err_sticky, step && (mode_reg == M_ERR_UNTERM), mode_reg == M_ERR_UNTERM, "unterminated-string error not sticky")
    `STC_ASSERT_NOW(a_err_word, (mode_reg == M_ERR_UNTERM) || (mode_reg == M_ERR_ESC), (lex.count == 2'd1) && (lex.res0.error_code != ERR_NONE), "error mode must give one error word")
    `STC_ASSERT_NOW(a_pair_order, lex.count == 2'd2, lex.res0.token_end && !lex.res0.has_char && !lex.res0.run_last && lex.res1.run_last, "two words must be end marker then token byte")

endmodule

`default_nettype wire

### rtl/stc_out_fifo.sv
// ----------------------------------------------------------------------------
// stc_out_fifo
// Result queue: takes up to two words per cycle while it has room, hands one per cycle to a ready sink.
// ----------------------------------------------------------------------------
`default_nettype none

`include "scene_text_tokenizer_unit_assert.svh"

module stc_out_fifo (
    input  wire logic              clk,
    input  wire logic              rst_n,
    input  wire logic              push_en,
    input  wire stc_pkg::lex_out_t push,
    output logic                   room,
    stc_out_if.source              tokens
);
    import stc_pkg::*;

    res_t                  entries [FIFO_DEPTH];
    logic [FIFO_PTR_W-1:0] wr_ptr_reg;
    logic [FIFO_PTR_W-1:0] wr_ptr_next;
    logic [FIFO_PTR_W-1:0] rd_ptr_reg;
    logic [FIFO_PTR_W-1:0] rd_ptr_next;
    logic [FIFO_CNT_W-1:0] count_reg;
    logic [FIFO_CNT_W-1:0] count_next;
    logic [1:0]            n_push;
    logic                  pop;
    res_t                  head;

    assign room   = (count_reg <= FIFO_CNT_W'(FIFO_DEPTH - 2));
    assign n_push = push_en ? push.count : 2'd0;
    assign pop    = tokens.valid && tokens.ready;
    assign head   = entries[rd_ptr_reg];

    assign wr_ptr_next = wr_ptr_reg + FIFO_PTR_W'(n_push);
    assign rd_ptr_next = rd_ptr_reg + FIFO_PTR_W'(pop);
    assign count_next  = count_reg + FIFO_CNT_W'(n_push) - FIFO_CNT_W'(pop);

    always_ff @(posedge clk)
    begin
        if (push_en && (push.count != 2'd0))
            entries[wr_ptr_reg] <= push.res0;
        if (push_en && (push.count == 2'd2))
            entries[wr_ptr_reg + FIFO_PTR_W'(1)] <= push.res1;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    assign tokens.valid       = (count_reg != '0);
    assign tokens.out_char    = head.out_char;
    assign tokens.has_char    = head.has_char;
    assign tokens.token_kind  = head.token_kind;
    assign tokens.token_start = head.token_start;
    assign tokens.token_end   = head.token_end;
    assign tokens.error_code  = head.error_code;
    assign tokens.run_last    = head.run_last;

    `STC_ASSERT_NOW(a_push_room, push_en, room, "push without room for two words")
    `STC_ASSERT_NOW(a_count_max, 1'b1, count_reg <= FIFO_CNT_W'(FIFO_DEPTH), "queue count beyond depth")
    `STC_ASSERT_NEXT(a_pop_only, pop && !push_en, count_reg == $past(count_reg) - 3'd1, "pop must lower count by one")

endmodule

`default_nettype wire

### rtl/scene_text_tokenizer_unit.sv
// ----------------------------------------------------------------------------
// scene_text_tokenizer_unit
// Byte-stream lexer: words, quoted strings, brackets and hash comments.
// ----------------------------------------------------------------------------
// Usage:
//   text   : one word per byte (func = 0) or end of input (func = 1).
//   tokens : zero, one or two words per text word, each token byte tagged
//            with kind and start/end marks; run_last flags the final word
//            of one text word. After a string fault every text word gives
//            one error word until reset.
//   APB    : register 0 at byte address 0, pass_comments (bit 0).
// Path: an accepted text word waits in the input register, is lexed from it once
//   the queue has room, and its token words go into the output queue for the sink.
// Throughput: one text word per cycle while each gives at most one token
//   word and the sink keeps up; a word ending a token before a quote or
//   bracket gives two token words, which drain one per cycle from the
//   four-entry output queue.
// Reset: lexer idle, queue empty, pass_comments cleared.
// Sink stall: the queue fills; text.ready drops once fewer than two queue
//   slots remain and a lexed word is waiting.
// ----------------------------------------------------------------------------
`default_nettype none

module scene_text_tokenizer_unit (
    input  wire logic                        clk,
    input  wire logic                        rst_n,
    input  wire logic                        psel,
    input  wire logic                        penable,
    input  wire logic                        pwrite,
    input  wire logic [stc_pkg::ADDR_W-1:0]  paddr,
    input  wire logic [31:0]                 pwdata,
    output logic      [31:0]                 prdata,
    output logic                             pready,
    stc_in_if.sink                           text,
    stc_out_if.source                        tokens
);
    import stc_pkg::*;

    logic       pass_comments_reg;
    logic       in_valid_reg;
    logic       in_valid_next;
    logic       in_func_reg;
    logic [7:0] in_char_reg;
    logic       room;
    logic       advance;
    logic       take;
    logic       cfg_wr;
    lex_out_t   lex;

    assign pready = 1'b1;
    assign cfg_wr = psel && penable && pwrite && (paddr == PASS_COMMENTS_ADDR);
    assign prdata = (paddr == PASS_COMMENTS_ADDR) ? {31'd0, pass_comments_reg} : 32'd0;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            pass_comments_reg <= 1'b0;
        else if (cfg_wr)
            pass_comments_reg <= pwdata[0];
    end

    assign advance       = in_valid_reg && room;
    assign text.ready    = !in_valid_reg || advance;
    assign take          = text.valid && text.ready;
    assign in_valid_next = take ? 1'b1 : (advance ? 1'b0 : in_valid_reg);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            in_valid_reg <= 1'b0;
        else
            in_valid_reg <= in_valid_next;
    end

    always_ff @(posedge clk)
    begin
        if (take)
        begin
            in_func_reg <= text.func;
            in_char_reg <= text.char_in;
        end
    end

    stc_lexer u_lexer (
        .clk           (clk),
        .rst_n         (rst_n),
        .step          (advance),
        .func          (in_func_reg),
        .char_in       (in_char_reg),
        .pass_comments (pass_comments_reg),
        .lex           (lex)
    );

    stc_out_fifo u_out_fifo (
        .clk     (clk),
        .rst_n   (rst_n),
        .push_en (advance),
        .push    (lex),
        .room    (room),
        .tokens  (tokens)
    );

endmodule

`default_nettype wire
